// ===== sv/vcf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package vcf_pkg;

	localparam int FrameLen = 11;
	localparam int InWidth = 32;
	localparam int ValWidth = 16;
	localparam int ProdWidth = 42;
	localparam int FracBits = 16;
	localparam int CntWidth = 4;

	localparam logic ActCommand = 1'b0;
	localparam logic ActCheck = 1'b1;

	localparam logic [7:0] FrameHead = 8'h7B;
	localparam logic [7:0] FrameTail = 8'h7D;
	localparam logic signed [10:0] ScaleFactor = 11'sd1000;
	localparam logic [7:0] TimeoutReset = 8'd3;
	localparam logic [7:0] ChecksMax = 8'd255;

	localparam logic signed [ValWidth-1:0] ValTop = 16'sh7FFF;
	localparam logic signed [ValWidth-1:0] ValBottom = 16'sh8000;

	// element i is frame byte i, element 0 goes out first
	typedef logic [FrameLen-1:0][7:0] frame_t;

	typedef struct packed {
		logic adv_s1;
		logic adv_s2;
	} pipe_ctrl_t;

endpackage
`default_nettype wire

// ===== sv/vcf_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
module vcf_lane (
	input  wire                                  clk,
	input  wire vcf_pkg::pipe_ctrl_t             ctrl,
	input  wire logic signed [vcf_pkg::InWidth-1:0] value,
	output logic [vcf_pkg::ValWidth-1:0]         scaled
);

	logic signed [vcf_pkg::ProdWidth-1:0] prod_s1;
	logic signed [vcf_pkg::ProdWidth-1:0] biased;
	logic signed [vcf_pkg::ProdWidth-vcf_pkg::FracBits-1:0] quot;
	logic [vcf_pkg::ValWidth-1:0] scaled_s2;

	always_ff @(posedge clk) begin
		if (ctrl.adv_s1) begin
			prod_s1 <= vcf_pkg::ProdWidth'(value) * vcf_pkg::ProdWidth'(vcf_pkg::ScaleFactor);
		end
	end

	// bias negatives so the shift truncates toward zero
	assign biased = prod_s1 + $signed({{(vcf_pkg::ProdWidth-vcf_pkg::FracBits){1'b0}},
		{vcf_pkg::FracBits{prod_s1[vcf_pkg::ProdWidth-1]}}});
	assign quot = biased[vcf_pkg::ProdWidth-1:vcf_pkg::FracBits];

	always_ff @(posedge clk) begin
		if (ctrl.adv_s2) begin
			if (quot > $signed((vcf_pkg::ProdWidth-vcf_pkg::FracBits)'(vcf_pkg::ValTop))) begin
				scaled_s2 <= vcf_pkg::ValTop;
			end else if (quot <
				$signed((vcf_pkg::ProdWidth-vcf_pkg::FracBits)'(vcf_pkg::ValBottom))) begin
				scaled_s2 <= vcf_pkg::ValBottom;
			end else begin
				scaled_s2 <= quot[vcf_pkg::ValWidth-1:0];
			end
		end
	end

	assign scaled = scaled_s2;

endmodule
`default_nettype wire

// ===== sv/vcf_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none
module vcf_merge (
	input  wire logic [vcf_pkg::ValWidth-1:0] x,
	input  wire logic [vcf_pkg::ValWidth-1:0] y,
	input  wire logic [vcf_pkg::ValWidth-1:0] z,
	input  wire logic                         stop,
	output vcf_pkg::frame_t                   frame
);

	logic [vcf_pkg::ValWidth-1:0] xv, yv, zv;

	// stop frames carry zero velocity whatever the lanes hold
	assign xv = stop ? '0 : x;
	assign yv = stop ? '0 : y;
	assign zv = stop ? '0 : z;

	always_comb begin
		frame[0]  = vcf_pkg::FrameHead;
		frame[1]  = 8'h00;
		frame[2]  = 8'h00;
		frame[3]  = xv[15:8];
		frame[4]  = xv[7:0];
		frame[5]  = yv[15:8];
		frame[6]  = yv[7:0];
		frame[7]  = zv[15:8];
		frame[8]  = zv[7:0];
		frame[9]  = vcf_pkg::FrameHead ^ xv[15:8] ^ xv[7:0] ^ yv[15:8] ^ yv[7:0]
			^ zv[15:8] ^ zv[7:0];
		frame[10] = vcf_pkg::FrameTail;
	end

endmodule
`default_nettype wire

// ===== sv/vcf_serializer.sv =====
`timescale 1ns / 1ps
`default_nettype none
module vcf_serializer (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire vcf_pkg::frame_t frame,
	input  wire                  stop,
	input  wire                  load_req,
	output logic                 load_ok,
	output logic                 out_valid,
	input  wire                  out_stall,
	output logic [7:0]           frame_byte,
	output logic                 frame_last,
	output logic                 is_stop_frame
);

	vcf_pkg::frame_t shift_q;
	logic [vcf_pkg::CntWidth-1:0] cnt_q;
	logic busy_q;
	logic stop_q;
	logic out_acc;
	logic done;

	assign out_acc = busy_q && !out_stall;
	assign done = out_acc && (cnt_q == vcf_pkg::CntWidth'(vcf_pkg::FrameLen - 1));
	assign load_ok = !busy_q || done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (load_req && load_ok) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
		end else if (out_acc) begin
			cnt_q <= cnt_q + 1'b1;
			if (done) begin
				busy_q <= 1'b0;
			end
		end
	end

	// advance one byte per accepted word
	always_ff @(posedge clk) begin
		if (load_req && load_ok) begin
			shift_q <= frame;
			stop_q <= stop;
		end else if (out_acc) begin
			shift_q <= {8'h00, shift_q[vcf_pkg::FrameLen-1:1]};
		end
	end

	assign out_valid = busy_q;
	assign frame_byte = shift_q[0];
	assign frame_last = (cnt_q == vcf_pkg::CntWidth'(vcf_pkg::FrameLen - 1));
	assign is_stop_frame = stop_q;

endmodule
`default_nettype wire

// ===== sv/velocity_command_framer_core.sv =====
// Velocity command framer.
// Input channel (in_valid / in_stall): action, linear_x, linear_y, angular_z.
// action 0 scales the three Q16.16 values by 1000 to int16 (truncate, saturate)
// in three parallel lanes and queues an eleven-byte frame; action 1 is a
// watchdog check that may queue a zero-velocity stop frame or nothing at all.
// Output channel (out_valid / out_stall): one frame byte per word, frame_last
// on the closing byte, is_stop_frame on every byte of a stop frame.
// Configuration (cfg_valid / cfg_ready / cfg_data): timeout_checks, always ready.
// Path: the first byte follows the accepting edge through the multiply stage,
// the scale/saturate stage and the frame load. Bytes go out one per cycle from
// the output shifter while the receiver does not stall; up to two further
// frames are queued while a frame drains. Checks that send nothing skip the pipeline.
// Reset: timeout_checks is 3 and the check counter is saturated at 255, so the
// first check already sends a stop frame. Pipeline and output are empty.
// A stalled receiver holds the current byte; the pipeline fills and then
// in_stall rises until the frame in flight drains.
`timescale 1ns / 1ps
`default_nettype none
module velocity_command_framer_core (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_stall,
	input  wire                action,
	input  wire logic signed [31:0] linear_x,
	input  wire logic signed [31:0] linear_y,
	input  wire logic signed [31:0] angular_z,
	output logic               out_valid,
	input  wire                out_stall,
	output logic [7:0]         frame_byte,
	output logic               frame_last,
	output logic               is_stop_frame,
	input  wire                cfg_valid,
	output logic               cfg_ready,
	input  wire logic [7:0]    cfg_data
);

	logic [7:0] timeout_q;
	logic [7:0] checks_q;
	logic [7:0] checks_next;
	logic in_acc;
	logic emit;
	logic valid_s1, valid_s2;
	logic stop_s1, stop_s2;
	logic load_ok;
	vcf_pkg::pipe_ctrl_t ctrl;
	logic [vcf_pkg::ValWidth-1:0] x_val, y_val, z_val;
	vcf_pkg::frame_t frame;

	assign cfg_ready = 1'b1;

	assign ctrl.adv_s2 = !valid_s2 || load_ok;
	assign ctrl.adv_s1 = !valid_s1 || ctrl.adv_s2;
	assign in_stall = !ctrl.adv_s1;
	assign in_acc = in_valid && !in_stall;

	always_comb begin
		if (action == vcf_pkg::ActCommand) begin
			checks_next = '0;
		end else if (checks_q == vcf_pkg::ChecksMax) begin
			checks_next = checks_q;
		end else begin
			checks_next = checks_q + 1'b1;
		end
	end

	assign emit = (action == vcf_pkg::ActCommand) || (checks_next >= timeout_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= vcf_pkg::TimeoutReset;
			checks_q <= vcf_pkg::ChecksMax;
		end else begin
			if (cfg_valid && cfg_ready) begin
				timeout_q <= cfg_data;
			end
			if (in_acc) begin
				checks_q <= checks_next;
			end
		end
	end

	// drop checks that send nothing at the door
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ctrl.adv_s1) begin
				valid_s1 <= in_acc && emit;
			end
			if (ctrl.adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.adv_s1) begin
			stop_s1 <= (action == vcf_pkg::ActCheck);
		end
		if (ctrl.adv_s2) begin
			stop_s2 <= stop_s1;
		end
	end

	vcf_lane u_lane_x (.clk(clk), .ctrl(ctrl), .value(linear_x), .scaled(x_val));
	vcf_lane u_lane_y (.clk(clk), .ctrl(ctrl), .value(linear_y), .scaled(y_val));
	vcf_lane u_lane_z (.clk(clk), .ctrl(ctrl), .value(angular_z), .scaled(z_val));

	vcf_merge u_merge (
		.x(x_val),
		.y(y_val),
		.z(z_val),
		.stop(stop_s2),
		.frame(frame)
	);

	vcf_serializer u_ser (
		.clk(clk),
		.arst_n(arst_n),
		.frame(frame),
		.stop(stop_s2),
		.load_req(valid_s2),
		.load_ok(load_ok),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.frame_byte(frame_byte),
		.frame_last(frame_last),
		.is_stop_frame(is_stop_frame)
	);

	a_cmd_clears: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (action == vcf_pkg::ActCommand) |=> checks_q == 8'd0)
		else $error("command did not clear the check counter");

	a_tail_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_last |-> frame_byte == vcf_pkg::FrameTail)
		else $error("closing byte is not the frame tail");

	a_head_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_last && !out_stall && valid_s2 |=>
		out_valid && frame_byte == vcf_pkg::FrameHead)
		else $error("queued frame did not follow the closing byte");

	a_s2_waits: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !load_ok |=> valid_s2 && $stable(stop_s2))
		else $error("pending frame lost while the shifter was busy");

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
module tb;

	localparam int QuietCycles = 8;
	localparam int PhaseItems = 22;
	localparam logic [7:0] TripLimit = 8'd16;

	typedef struct {
		logic act;
		logic signed [31:0] lin_x;
		logic signed [31:0] lin_y;
		logic signed [31:0] ang_z;
	} vel_cmd_t;

	typedef struct {
		logic [7:0] data;
		logic last;
		logic stop;
	} frame_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic action = 1'b0;
	logic signed [31:0] linear_x = '0;
	logic signed [31:0] linear_y = '0;
	logic signed [31:0] angular_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] frame_byte;
	logic frame_last;
	logic is_stop_frame;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [7:0] cfg_data = '0;

	vel_cmd_t pending_cmds[$];
	vel_cmd_t cmd_on_bus;
	frame_word_t bytes_due[$];

	logic [7:0] timeout_model = vcf_pkg::TimeoutReset;
	logic [7:0] checks_since_cmd = vcf_pkg::ChecksMax;
	int send_gap_pct = 0;
	int stall_pct = 0;
	int mismatches = 0;

	velocity_command_framer_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.linear_x(linear_x),
		.linear_y(linear_y),
		.angular_z(angular_z),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.frame_byte(frame_byte),
		.frame_last(frame_last),
		.is_stop_frame(is_stop_frame),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Q16.16 times 1000, truncated toward zero, clamped to int16
	function automatic logic [15:0] scale_velocity(input logic signed [31:0] v);
		longint q;
		q = (longint'(v) * longint'(vcf_pkg::ScaleFactor)) / 65536;
		if (q > longint'(vcf_pkg::ValTop))
			q = longint'(vcf_pkg::ValTop);
		else if (q < longint'(vcf_pkg::ValBottom))
			q = longint'(vcf_pkg::ValBottom);
		return q[15:0];
	endfunction

	function automatic void queue_frame(input logic [15:0] x, input logic [15:0] y,
			input logic [15:0] z, input logic stop);
		logic [7:0] b [vcf_pkg::FrameLen];
		logic [7:0] sum;
		frame_word_t w;
		b[0] = vcf_pkg::FrameHead;
		b[1] = 8'h00;
		b[2] = 8'h00;
		b[3] = x[15:8];
		b[4] = x[7:0];
		b[5] = y[15:8];
		b[6] = y[7:0];
		b[7] = z[15:8];
		b[8] = z[7:0];
		sum = 8'h00;
		for (int i = 0; i < 9; i++)
			sum ^= b[i];
		b[9] = sum;
		b[10] = vcf_pkg::FrameTail;
		for (int i = 0; i < vcf_pkg::FrameLen; i++) begin
			w.data = b[i];
			w.last = (i == vcf_pkg::FrameLen - 1);
			w.stop = stop;
			bytes_due.push_back(w);
		end
	endfunction

	function automatic void frame_for_cmd(input vel_cmd_t c);
		if (c.act == vcf_pkg::ActCommand) begin
			checks_since_cmd = 8'd0;
			queue_frame(scale_velocity(c.lin_x), scale_velocity(c.lin_y),
				scale_velocity(c.ang_z), 1'b0);
		end else begin
			if (checks_since_cmd != vcf_pkg::ChecksMax)
				checks_since_cmd++;
			if (checks_since_cmd >= timeout_model)
				queue_frame(16'h0000, 16'h0000, 16'h0000, 1'b1);
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		$display("%0t: %s: got %h, want %h", $time, what, got, want);
		mismatches++;
	endtask

	// a third within the int16 range after scaling, a third around the clamp, a third wild
	function automatic logic signed [31:0] rand_q16();
		case ($urandom_range(2))
			0: return $urandom;
			1: return 32'($urandom_range(0, 32'h0080_0000)) - 32'h0040_0000;
			default: return 32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
		endcase
	endfunction

	function automatic void push_cmd(input logic act, input logic signed [31:0] x,
			input logic signed [31:0] y, input logic signed [31:0] z);
		vel_cmd_t c;
		c.act = act;
		c.lin_x = x;
		c.lin_y = y;
		c.ang_z = z;
		pending_cmds.push_back(c);
	endfunction

	// bursts of commands, then a run of checks, now and then long enough to trip the watchdog
	task automatic fill_random(input int n_items);
		int added;
		int k;
		added = 0;
		while (added < n_items) begin
			repeat ($urandom_range(1, 3)) begin
				push_cmd(vcf_pkg::ActCommand, rand_q16(), rand_q16(), rand_q16());
				added++;
			end
			if ($urandom_range(4) == 0 && timeout_model < TripLimit)
				k = int'(timeout_model) + $urandom_range(0, 3);
			else
				k = $urandom_range(0, 4);
			repeat (k) begin
				push_cmd(vcf_pkg::ActCheck, $urandom, $urandom, $urandom);
				added++;
			end
		end
	endtask

	// sample after the edge has settled so a word just put on the bus is seen
	task automatic wait_quiet();
		@(negedge clk);
		while (pending_cmds.size() != 0 || in_valid || bytes_due.size() != 0)
			@(negedge clk);
		repeat (QuietCycles) @(posedge clk);
	endtask

	task automatic write_timeout(input logic [7:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		timeout_model = value;
		cfg_valid <= 1'b0;
	endtask

	// driver: hold the word while stalled, otherwise take the next one or idle
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				frame_for_cmd(cmd_on_bus);
			if (!in_valid || !in_stall) begin
				if (pending_cmds.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
					cmd_on_bus = pending_cmds.pop_front();
					in_valid <= 1'b1;
					action <= cmd_on_bus.act;
					linear_x <= cmd_on_bus.lin_x;
					linear_y <= cmd_on_bus.lin_y;
					angular_z <= cmd_on_bus.ang_z;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		frame_word_t w;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (bytes_due.size() == 0) begin
					report_mismatch("frame_byte with nothing due", frame_byte, 8'h00);
				end else begin
					w = bytes_due.pop_front();
					if (frame_byte !== w.data)
						report_mismatch("frame_byte", frame_byte, w.data);
					if (frame_last !== w.last)
						report_mismatch("frame_last", 8'(frame_last), 8'(w.last));
					if (is_stop_frame !== w.stop)
						report_mismatch("is_stop_frame", 8'(is_stop_frame), 8'(w.stop));
				end
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	initial begin
		logic [7:0] timeout_plan [8];
		int gap_plan [4];
		int stall_plan [4];
		timeout_plan = '{8'd1, 8'd255, 8'd0, 8'd2, 8'd7, 8'd1, 8'd255, 8'd3};
		timeout_plan[5] = 8'($urandom_range(1, 255));
		gap_plan = '{0, 48, 0, 37};
		stall_plan = '{0, 0, 48, 37};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// counter comes out of reset saturated: the first check already stops
		push_cmd(vcf_pkg::ActCheck, 32'sd0, 32'sd0, 32'sd0);
		push_cmd(vcf_pkg::ActCommand, 32'sd0, 32'sd0, 32'sd0);
		push_cmd(vcf_pkg::ActCheck, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
		push_cmd(vcf_pkg::ActCheck, 32'sd0, 32'sd0, 32'sd0);
		push_cmd(vcf_pkg::ActCheck, 32'sd0, 32'sd0, 32'sd0);
		push_cmd(vcf_pkg::ActCheck, 32'sd0, 32'sd0, 32'sd0);
		push_cmd(vcf_pkg::ActCommand, 32'h7FFF_FFFF, 32'h8000_0000, -32'sd1);
		push_cmd(vcf_pkg::ActCommand, 32'h8000_0000, 32'h7FFF_FFFF, 32'sd1);
		push_cmd(vcf_pkg::ActCommand, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		// just below and above the clamp on either side
		push_cmd(vcf_pkg::ActCommand, 32'sd2147483, 32'sd2147484, -32'sd2147483);
		push_cmd(vcf_pkg::ActCommand, -32'sd2147484, -32'sd2147549, 32'sd2147418);
		// truncation toward zero on small negatives
		push_cmd(vcf_pkg::ActCommand, -32'sd65, -32'sd66, 32'sd66);
		push_cmd(vcf_pkg::ActCommand, 32'sd65536, -32'sd65536, 32'sh5555_5555);
		push_cmd(vcf_pkg::ActCommand, 32'shAAAA_AAAA, 32'sh0001_8000, -32'sh0001_8000);
		push_cmd(vcf_pkg::ActCheck, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_cmd(vcf_pkg::ActCheck, 32'sd0, 32'sd0, 32'sd0);
		push_cmd(vcf_pkg::ActCheck, 32'sd0, 32'sd0, 32'sd0);
		push_cmd(vcf_pkg::ActCommand, rand_q16(), rand_q16(), rand_q16());
		push_cmd(vcf_pkg::ActCheck, 32'sd0, 32'sd0, 32'sd0);
		push_cmd(vcf_pkg::ActCheck, 32'sd0, 32'sd0, 32'sd0);
		push_cmd(vcf_pkg::ActCheck, 32'sd0, 32'sd0, 32'sd0);
		wait_quiet();

		for (int p = 0; p < 8; p++) begin
			write_timeout(timeout_plan[p]);
			send_gap_pct = gap_plan[p % 4];
			stall_pct = stall_plan[p % 4];
			fill_random(PhaseItems);
			wait_quiet();
		end

		repeat (20) @(posedge clk);
		if (mismatches == 0 && bytes_due.size() == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

	initial begin
		#(5_000_000);
		$display("tb failed");
		$finish;
	end

endmodule
